// ===== src/krq_pkg.sv =====
// Package for the keyed request queue: sizes, entry layout, codes and FSM states.
// No dependencies; krq_ctrl, the top level and the checker import it.
`timescale 1ns / 1ps

package krq_pkg;

    // Queue geometry (depth is a power of two so the ring wraps by truncation)
    localparam int QUEUE_DEPTH = 256;
    localparam int HANDLE_BITS = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_W       = 9;
    localparam int LIM_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int OUT_CNT_W   = 9;
    localparam int HANDLE_W    = 16;
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(255);

    typedef struct packed {
        logic [31:0]            seq;
        logic [31:0]            src;
        logic [31:0]            dst;
        logic [7:0]             dev;
        logic [HANDLE_BITS-1:0] handle;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_GET = 2'd1,
        CMD_DEL = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_OLD  = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_COMMIT,
        S_OUT
    } t_state;

    // Request from the controller to the entry memory
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        t_entry             wdata;
        logic [ADDR_W-1:0]  raddr;
    } t_ram_req;

endpackage

// ===== src/krq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module krq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/krq_ctrl.sv =====
// Queue controller: ring of entries in memory, scan, in-place removal by shifting.
// Depends on krq_pkg; drives one krq_ram instance through a t_ram_req.
`timescale 1ns / 1ps

module krq_ctrl import krq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [LIM_W-1:0]      i_limit,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_command,
    input  t_entry                i_key,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [HANDLE_W-1:0]   o_found_handle,
    output logic                  o_evicted,
    output logic [HANDLE_W-1:0]   o_evicted_handle,
    output logic [CNT_W-1:0]      o_count,
    output t_ram_req              o_ram,
    input  t_entry                i_rdata
);

    t_state                 r_state, n_state;
    logic [ADDR_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]       r_count, n_count;
    t_cmd                   r_cmd, n_cmd;
    t_entry                 r_key, n_key;
    logic [CNT_W-1:0]       r_ptr, n_ptr;
    logic                   r_chk_vld, n_chk_vld;
    logic [CNT_W-1:0]       r_chk_idx, n_chk_idx;
    logic [CNT_W-1:0]       r_hit_idx, n_hit_idx;
    logic                   r_dup, n_dup;
    logic [HANDLE_BITS-1:0] r_first_handle, n_first_handle;
    t_status                r_status, n_status;
    logic [HANDLE_W-1:0]    r_found_handle, n_found_handle;
    logic                   r_evicted, n_evicted;
    logic [HANDLE_W-1:0]    r_evicted_handle, n_evicted_handle;

    logic              accept;
    logic              issue;
    logic              id_eq;
    logic              full_eq;
    logic              chk_last;
    logic              old_now;
    logic              dup_now;
    logic              hit;
    logic              shift_done;
    logic              evict;
    logic [CNT_W-1:0]  last_idx;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign last_idx = r_count - CNT_W'(1);
    assign issue    = (r_ptr < r_count);
    assign id_eq    = (i_rdata.seq == r_key.seq);
    assign full_eq  = id_eq && (i_rdata.src == r_key.src) && (i_rdata.dst == r_key.dst)
                      && (i_rdata.dev == r_key.dev);
    assign chk_last = r_chk_vld && (r_chk_idx == last_idx);
    assign old_now  = chk_last && ($signed(i_rdata.seq) > $signed(r_key.seq));
    assign dup_now  = r_dup || (r_chk_vld && full_eq);
    assign hit      = r_chk_vld && id_eq;
    assign shift_done = chk_last || (r_hit_idx == last_idx);
    assign evict    = (r_count != '0) && (LIM_W'(r_count) >= i_limit);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_command))
                        CMD_ADD:          n_state = (r_count == '0) ? S_COMMIT : S_SCAN;
                        CMD_GET, CMD_DEL: n_state = (r_count == '0) ? S_OUT : S_SCAN;
                        default:          n_state = S_OUT;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_cmd == CMD_ADD) begin
                    if (chk_last) begin
                        n_state = (old_now || dup_now) ? S_OUT : S_COMMIT;
                    end
                end else if (hit) begin
                    n_state = S_SHIFT;
                end else if (chk_last) begin
                    n_state = S_OUT;
                end
            end
            S_SHIFT: begin
                if (shift_done) begin
                    n_state = S_OUT;
                end
            end
            S_COMMIT: n_state = S_OUT;
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        n_head           = r_head;
        n_count          = r_count;
        n_cmd            = r_cmd;
        n_key            = r_key;
        n_ptr            = r_ptr;
        n_chk_vld        = 1'b0;
        n_chk_idx        = r_chk_idx;
        n_hit_idx        = r_hit_idx;
        n_dup            = r_dup;
        n_first_handle   = r_first_handle;
        n_status         = r_status;
        n_found_handle   = r_found_handle;
        n_evicted        = r_evicted;
        n_evicted_handle = r_evicted_handle;
        o_ram.we         = 1'b0;
        o_ram.waddr      = r_head + r_count[ADDR_W-1:0];
        o_ram.wdata      = r_key;
        o_ram.raddr      = r_head + r_ptr[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd            = t_cmd'(i_command);
                    n_key            = i_key;
                    n_ptr            = '0;
                    n_dup            = 1'b0;
                    n_found_handle   = '0;
                    n_evicted        = 1'b0;
                    n_evicted_handle = '0;
                    n_status         = ST_DONE;
                    if ((t_cmd'(i_command) == CMD_GET || t_cmd'(i_command) == CMD_DEL)
                        && r_count == '0) begin
                        n_status = ST_MISS;
                    end
                end
            end
            S_SCAN: begin
                // stream reads, check each entry in the cycle after its read is issued
                if (issue) begin
                    n_ptr     = r_ptr + CNT_W'(1);
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_ptr;
                end
                if (r_cmd == CMD_ADD) begin
                    n_dup = dup_now;
                    if (r_chk_vld && r_chk_idx == '0) begin
                        n_first_handle = i_rdata.handle;
                    end
                    if (chk_last) begin
                        if (old_now) begin
                            n_status = ST_OLD;
                        end else if (dup_now) begin
                            n_status = ST_DUP;
                        end
                    end
                end else if (hit) begin
                    // restart the stream just behind the match for the shift
                    n_hit_idx = r_chk_idx;
                    n_ptr     = r_chk_idx + CNT_W'(1);
                    n_chk_vld = 1'b0;
                    if (r_cmd == CMD_GET) begin
                        n_found_handle = HANDLE_W'(i_rdata.handle);
                    end
                end else if (chk_last) begin
                    n_status = ST_MISS;
                end
            end
            S_SHIFT: begin
                // move each later entry down one place; reads run ahead of writes
                if (issue) begin
                    n_ptr     = r_ptr + CNT_W'(1);
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_ptr;
                end
                if (r_chk_vld) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_head + r_chk_idx[ADDR_W-1:0] - ADDR_W'(1);
                    o_ram.wdata = i_rdata;
                end
                if (shift_done) begin
                    n_count   = last_idx;
                    n_chk_vld = 1'b0;
                end
            end
            S_COMMIT: begin
                // evicting and appending land on the same ring slot only when the ring holds QUEUE_DEPTH entries
                o_ram.we  = 1'b1;
                n_evicted = evict;
                if (evict) begin
                    n_head           = r_head + ADDR_W'(1);
                    n_evicted_handle = HANDLE_W'(r_first_handle);
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd            <= n_cmd;
        r_key            <= n_key;
        r_ptr            <= n_ptr;
        r_chk_idx        <= n_chk_idx;
        r_hit_idx        <= n_hit_idx;
        r_dup            <= n_dup;
        r_first_handle   <= n_first_handle;
        r_status         <= n_status;
        r_found_handle   <= n_found_handle;
        r_evicted        <= n_evicted;
        r_evicted_handle <= n_evicted_handle;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_status         = r_status;
    assign o_found_handle   = r_found_handle;
    assign o_evicted        = r_evicted;
    assign o_evicted_handle = r_evicted_handle;
    assign o_count          = r_count;

endmodule

// ===== src/keyed_request_queue_unit.sv =====
// Top level of the keyed request queue: limit register, controller and entry RAM.
// Depends on krq_pkg, krq_ram and krq_ctrl.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | command, seq_id, addresses, device, handle
//  out     | output    | o_out_valid / i_out_stall  | status, handles, evicted, count, empty
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | max_entries (9 bits)
//
// The scan of an item reads one entry a cycle from the single read port of the entry RAM,
// and a removal shifts the later entries down one a cycle through the same port.
// One item is in flight at a time; o_in_stall stays high until its result is taken.
// Reset is synchronous; the RAM needs no clearing pass, only head and count reset.
`timescale 1ns / 1ps

module keyed_request_queue_unit import krq_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_command,
    input  logic signed [31:0]     i_seq_id,
    input  logic [31:0]            i_src_addr,
    input  logic [31:0]            i_dst_addr,
    input  logic [7:0]             i_device_id,
    input  logic [HANDLE_W-1:0]    i_task_handle,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [HANDLE_W-1:0]    o_found_handle,
    output logic                   o_evicted,
    output logic [HANDLE_W-1:0]    o_evicted_handle,
    output logic [OUT_CNT_W-1:0]   o_entry_count,
    output logic                   o_is_empty,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    logic [CFG_W-1:0] r_max_entries;
    logic [LIM_W-1:0] limit;
    logic [CNT_W-1:0] count;
    t_entry           key;
    t_entry           rdata;
    t_ram_req         ram_req;

    // hold the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_entries <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // clamp the limit to one .. depth
    always_comb begin
        limit = LIM_W'(r_max_entries);
        if (r_max_entries == '0) begin
            limit = LIM_W'(1);
        end else if (LIM_W'(r_max_entries) > LIM_W'(QUEUE_DEPTH)) begin
            limit = LIM_W'(QUEUE_DEPTH);
        end
    end

    assign key.seq    = i_seq_id;
    assign key.src    = i_src_addr;
    assign key.dst    = i_dst_addr;
    assign key.dev    = i_device_id;
    assign key.handle = HANDLE_BITS'(i_task_handle);

    krq_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_limit          (limit),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_key            (key),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_handle   (o_found_handle),
        .o_evicted        (o_evicted),
        .o_evicted_handle (o_evicted_handle),
        .o_count          (count),
        .o_ram            (ram_req),
        .i_rdata          (rdata)
    );

    krq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    assign o_entry_count = OUT_CNT_W'(count);
    assign o_is_empty    = (count == '0);

endmodule

// ===== src/krq_checker.sv =====
// Port-level checks for keyed_request_queue_unit, bound onto the top level.
// Depends on krq_pkg.
`timescale 1ns / 1ps

module krq_checker import krq_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [1:0]           o_status,
    input logic [HANDLE_W-1:0]  o_found_handle,
    input logic                 o_evicted,
    input logic [HANDLE_W-1:0]  o_evicted_handle,
    input logic [OUT_CNT_W-1:0] o_entry_count,
    input logic                 o_is_empty
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_entry_count) && $stable(o_found_handle))
        else $error("stalled result changed");

    // empty flag agrees with the count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    // a rejected or missed request evicts and returns nothing
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_DONE) |->
            !o_evicted && (o_found_handle == '0) && (o_evicted_handle == '0))
        else $error("rejected transaction carries handles");

    // one transaction at a time: input stalls after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while busy");

    // the count never exceeds the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= OUT_CNT_W'(QUEUE_DEPTH)))
        else $error("count beyond queue depth");

endmodule

bind keyed_request_queue_unit krq_checker u_krq_checker (.*);
